>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int KIND_W         = 2;
    localparam int BLOCK_W        = 10;
    localparam int COUNT_W        = 11;
    localparam int BASE_W         = COUNT_W + 1;
    localparam int DEF_MAX_BLOCKS = 1024;
    localparam int DEF_WORD_BITS  = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET   = 2'd0,
        KIND_UNSET = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_FIND  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK,
        ST_MODIFY,
        ST_FIND,
        ST_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_CUR,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic fire;
        logic find;
        logic skip;
    } req_t;

    typedef struct packed {
        logic    init;
        logic    step;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wipe;
        logic    load_out;
        logic    out_zero;
    } ctl_t;

    typedef struct packed {
        logic in_word;
        logic at_end;
        logic free_ok;
        logic addr_last;
    } stat_t;

endpackage

>>> rtl/bba_mem.sv
`timescale 1ns / 1ps

module bba_mem
    import bba_pkg::*;
#(
    parameter int WORD_BITS  = DEF_WORD_BITS,
    parameter int WORD_COUNT = DEF_MAX_BLOCKS / DEF_WORD_BITS,
    localparam int AW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] store_reg [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bba_scan.sv
`timescale 1ns / 1ps

module bba_scan
    import bba_pkg::*;
#(
    parameter int WORD_BITS  = DEF_WORD_BITS,
    parameter int WORD_COUNT = DEF_MAX_BLOCKS / DEF_WORD_BITS,
    localparam int AW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl,
    input  kind_t                kind,
    input  logic [BLOCK_W-1:0]   blk,
    input  logic                 expect_used,
    input  logic [COUNT_W-1:0]   count,
    input  logic [WORD_BITS-1:0] rd_data,
    output logic [AW-1:0]        rd_addr,
    output logic [AW-1:0]        wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    output logic [COUNT_W-1:0]   found,
    output logic                 match,
    output stat_t                stat
);

    localparam int OW = $clog2(WORD_BITS);

    // Words hold block base + i in bit i; the layout is internal to the block.
    logic [BASE_W-1:0]    base_reg;
    logic [BASE_W-1:0]    base_next;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        addr_next;
    logic [AW-1:0]        addr_inc;
    logic [BASE_W-1:0]    base_top;
    logic [BASE_W-1:0]    blk_ext;
    logic [BASE_W-1:0]    count_ext;
    logic [BASE_W-1:0]    cand;
    logic [OW-1:0]        offset;
    logic [OW-1:0]        pos;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;

    always_comb
    begin
        base_next = base_reg;
        addr_next = addr_reg;
        if (ctl.init)
        begin
            base_next = '0;
            addr_next = '0;
        end
        else if (ctl.step)
        begin
            base_next = base_top;
            addr_next = addr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
            addr_reg <= addr_next;
        end
    end

    assign addr_inc  = (addr_reg == AW'(WORD_COUNT - 1)) ? '0 : addr_reg + 1'b1;
    assign base_top  = base_reg + BASE_W'(WORD_BITS);
    assign blk_ext   = BASE_W'(blk);
    assign count_ext = BASE_W'(count);
    assign offset    = OW'(blk_ext - base_reg);
    assign mask      = WORD_BITS'(1) << offset;

    assign free_bits = ~rd_data;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                pos = pos | OW'(i);
            end
        end
    end

    assign cand = base_reg + BASE_W'(pos);

    assign stat.in_word   = blk_ext < base_top;
    assign stat.at_end    = base_top >= count_ext;
    assign stat.free_ok   = (|free_bits) && (cand < count_ext);
    assign stat.addr_last = addr_reg == AW'(WORD_COUNT - 1);

    assign found = stat.free_ok ? COUNT_W'(cand) : count;
    assign match = (|(rd_data & mask)) == expect_used;

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_CUR:  rd_addr = addr_reg;
            RD_NEXT: rd_addr = addr_inc;
            default: rd_addr = '0;
        endcase
    end

    assign wr_addr = addr_reg;

    always_comb
    begin
        if (ctl.wipe)
        begin
            wr_data = '0;
        end
        else
        begin
            unique case (kind)
                KIND_SET:   wr_data = rd_data | mask;
                KIND_UNSET: wr_data = rd_data & ~mask;
                KIND_CHECK: wr_data = rd_data;
                KIND_FIND:  wr_data = rd_data | lowest;
                default:    wr_data = rd_data;
            endcase
        end
    end

endmodule

>>> rtl/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl
    import bba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  stat_t stat,
    input  logic  out_free,
    output logic  idle,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.fire)
                begin
                    if (req.skip)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else if (req.find)
                    begin
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK:
            begin
                if (stat.in_word)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                if (out_free && (stat.free_ok || stat.at_end))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        idle = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.wipe  = 1'b1;
                ctl.wr_en = 1'b1;
                ctl.step  = 1'b1;
            end
            ST_IDLE:
            begin
                idle       = 1'b1;
                ctl.rd_sel = RD_ZERO;
                if (req.fire)
                begin
                    ctl.init  = 1'b1;
                    ctl.rd_en = req.find && !req.skip;
                end
            end
            ST_SEEK:
            begin
                ctl.rd_sel = RD_CUR;
                if (stat.in_word)
                begin
                    ctl.rd_en = 1'b1;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            ST_MODIFY:
            begin
                if (out_free)
                begin
                    ctl.wr_en    = 1'b1;
                    ctl.load_out = 1'b1;
                end
            end
            ST_FIND:
            begin
                ctl.rd_sel = RD_NEXT;
                if (out_free)
                begin
                    priority if (stat.free_ok)
                    begin
                        ctl.wr_en    = 1'b1;
                        ctl.load_out = 1'b1;
                    end
                    else if (stat.at_end)
                    begin
                        ctl.load_out = 1'b1;
                    end
                    else
                    begin
                        ctl.step  = 1'b1;
                        ctl.rd_en = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_zero = 1'b1;
                end
            end
            default: ctl = '0;
        endcase
    end

`ifndef SYNTHESIS
    // A finished result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n) ctl.load_out |-> out_free)
        else $error("result loaded while the output register was occupied");

    // The clearing pass runs once after reset and is never re-entered.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
        else $error("clearing pass re-entered");

    // A read-modify-write always follows the seek that fetched its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_MODIFY) |-> $past(state_reg) == ST_SEEK)
        else $error("modify entered without a seek");

    // No word is written while the sequencer is idle or still seeking the word that holds the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEEK || state_reg == ST_IDLE) |-> !ctl.wr_en)
        else $error("bitmap written outside a modify, find or clear step");
`endif

endmodule

>>> rtl/block_bitmap_allocator.sv
`timescale 1ns / 1ps
// Set, unset and check step through the words to the one holding the block, read it, then write it
// back and load the result; a block at or above the count gives a zero result without a bitmap access.
// Find and set sets the first free block below the count, scanning in order, else returns the count.
// The next word is accepted only once the previous one has left the sequencer.
// The rate is set by at most one bitmap memory read per cycle and a single shared scan unit.
// Reset clears control state and block_count to 1024, then a clearing pass zeroes each of the
// WORD_COUNT bitmap words (32 by default) in turn; no word is accepted meanwhile.

module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = DEF_WORD_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // block [9:0], expect_used [10], zero [15:11]
    input  logic [KIND_W-1:0]    s_axis_tuser,  // kind [1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // found_block [10:0], check_match [11], zero [15:12]
);

    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [COUNT_W-1:0]   block_count_reg;
    logic [COUNT_W-1:0]   count_eff;
    kind_t                kind_reg;
    logic [BLOCK_W-1:0]   block_reg;
    logic                 expect_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   found_block_reg;
    logic [COUNT_W-1:0]   found_block_next;
    logic                 check_match_reg;
    logic                 check_match_next;
    logic                 out_free;
    logic                 idle;
    req_t                 req;
    ctl_t                 ctl;
    stat_t                stat;
    kind_t                in_kind;
    logic [BLOCK_W-1:0]   in_block;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic [COUNT_W-1:0]   found;
    logic                 match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_wdata;
        end
    end

    assign count_eff = (int'(block_count_reg) > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS)
                                                            : block_count_reg;

    assign in_kind  = kind_t'(s_axis_tuser);
    assign in_block = s_axis_tdata[BLOCK_W-1:0];

    assign s_axis_tready = idle;
    assign req.fire      = s_axis_tvalid && s_axis_tready;
    assign req.find      = in_kind == KIND_FIND;
    assign req.skip      = (in_kind == KIND_FIND) ? (count_eff == '0)
                                                  : (COUNT_W'(in_block) >= count_eff);

    always_ff @(posedge clk)
    begin
        if (req.fire)
        begin
            kind_reg   <= in_kind;
            block_reg  <= in_block;
            expect_reg <= s_axis_tdata[BLOCK_W];
        end
    end

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .stat     (stat),
        .out_free (out_free),
        .idle     (idle),
        .ctl      (ctl)
    );

    bba_scan #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .kind        (kind_reg),
        .blk         (block_reg),
        .expect_used (expect_reg),
        .count       (count_eff),
        .rd_data     (rd_data),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .found       (found),
        .match       (match),
        .stat        (stat)
    );

    bba_mem #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT)
    ) u_mem (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_axis_tready;

    assign found_block_next = (kind_reg == KIND_FIND && !ctl.out_zero) ? found : '0;
    assign check_match_next = (kind_reg == KIND_CHECK && !ctl.out_zero) ? match : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            found_block_reg <= found_block_next;
            check_match_reg <= check_match_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, check_match_reg, found_block_reg};

endmodule
